>>> rtl/fbfl_pkg.sv
// Shared types and constants of the flash block free list manager.
// Depends on nothing; fbfl_div and the top module import it.
package fbfl_pkg;

  // request codes
  localparam logic [1:0] REQ_GET = 2'd0;
  localparam logic [1:0] REQ_PUT = 2'd1;
  localparam logic [1:0] REQ_BAD = 2'd2;
  localparam logic [1:0] REQ_MAP = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_RESERVE = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_SKIP    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_BPL   = 2'd0;
  localparam logic [1:0] CFG_PPB   = 2'd1;
  localparam logic [1:0] CFG_RSV   = 2'd2;
  localparam logic [1:0] CFG_LIMIT = 2'd3;

  // block mark: state in [1:0], mapped flag in [2]
  localparam logic [1:0] MK_FREE = 2'd0;
  localparam logic [1:0] MK_USED = 2'd1;
  localparam logic [1:0] MK_BAD  = 2'd2;
  localparam int         MKW     = 3;

  // field widths
  localparam int BPLW = 11;
  localparam int PPBW = 13;
  localparam int PAW  = 40;
  localparam int PLW  = BPLW + PPBW;
  localparam int BIDW = 13;
  localparam int CFGW = 40;

  // register reset values
  localparam logic [BPLW-1:0] RST_BPL   = 11'd1024;
  localparam logic [PPBW-1:0] RST_PPB   = 13'd256;
  localparam logic [BPLW-1:0] RST_RSV   = 11'd2;
  localparam logic [PAW-1:0]  PAGE_ALL  = 40'hFF_FFFF_FFFF;

  // divider datapath
  localparam int DVW = 48;
  localparam int DQW = 16;
  localparam int SCW = 5;

  typedef struct packed {
    logic           start;
    logic [DVW-1:0] dividend;
    logic [DVW-1:0] divisor;   // pre-shifted to the top quotient bit
    logic [SCW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [DQW-1:0] quot;
    logic [DVW-1:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/fbfl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/fbfl_div.sv
// Restoring divider, one quotient bit per cycle, for page address splitting.
// Depends on fbfl_pkg (div_req_t, div_rsp_t).
module fbfl_div import fbfl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DVW-1:0] rem_r, rem_nxt;
  logic [DVW-1:0] dsr_r, dsr_nxt;
  logic [DQW-1:0] q_r, q_nxt;
  logic [SCW-1:0] cnt_r, cnt_nxt;
  logic           done_r, done_nxt;
  logic           ge;

  assign ge = rem_r >= dsr_r;

  always_comb begin
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = req.dividend;
      dsr_nxt = req.divisor;
      q_nxt   = '0;
      cnt_nxt = req.steps;
    end else if (cnt_r != '0) begin
      if (ge) begin
        rem_nxt = rem_r - dsr_r;
      end
      q_nxt    = {q_r[DQW-2:0], ge};
      dsr_nxt  = dsr_r >> 1;
      cnt_nxt  = cnt_r - SCW'(1);
      done_nxt = (cnt_r == SCW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule

>>> rtl/flash_block_free_list_manager_top.sv
// Get/put/mark-bad: an accepted request passes S_PRE, S_ADDR and S_MOD; the result
// strobe is registered from S_MOD (from S_PRE when rejected up front).
// Map page: the bit-serial divider splits the address into LUN and block.
// One item at a time; busy stays high until the result strobe. Receiver cannot stall.
// After reset and after each blocks_per_lun write, a clearing pass over all
// LUN_COUNT*MAX_BLOCKS_PER_LUN slots rebuilds the block memories (busy high).
// Depends on fbfl_pkg, fbfl_ram, fbfl_div.
module flash_block_free_list_manager_top import fbfl_pkg::*; #(
  parameter int LUN_COUNT          = 8,
  parameter int MAX_BLOCKS_PER_LUN = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_req_type,
  input  logic [2:0]       in_lun,
  input  logic [9:0]       in_block_index,
  input  logic             in_for_gc,
  input  logic [PAW-1:0]   in_page_address,
  output logic             out_strobe,
  output logic [2:0]       out_status,
  output logic [BIDW-1:0]  out_block_id,
  output logic [BPLW-1:0]  out_free_count,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFGW-1:0]  cfg_wdata
);

  localparam int LW    = (LUN_COUNT > 1) ? $clog2(LUN_COUNT) : 1;
  localparam int BW    = $clog2(MAX_BLOCKS_PER_LUN);
  localparam int DEPTH = LUN_COUNT * MAX_BLOCKS_PER_LUN;
  localparam int AW    = $clog2(DEPTH);
  localparam int CPW   = PLW + LW + 1;
  localparam int BMW   = LW + BPLW + 1;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_PRE   = 10'b00_0000_0100,
    S_MUL   = 10'b00_0000_1000,
    S_CAP   = 10'b00_0001_0000,
    S_CHKM  = 10'b00_0010_0000,
    S_DIVL  = 10'b00_0100_0000,
    S_DIVB  = 10'b00_1000_0000,
    S_ADDR  = 10'b01_0000_0000,
    S_MOD   = 10'b10_0000_0000
  } state_t;

  function automatic logic [AW-1:0] slot(input logic [LW-1:0] l, input logic [BW-1:0] i);
    return AW'(int'(l) * MAX_BLOCKS_PER_LUN + int'(i));
  endfunction

  // configuration
  logic [BPLW-1:0] bpl_r;
  logic [PPBW-1:0] ppb_r;
  logic [BPLW-1:0] rsv_r;
  logic [PAW-1:0]  lim_r;
  logic [BPLW-1:0] bpl_eff;
  logic [PPBW-1:0] ppb_eff;

  // control and working registers
  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [BW-1:0]     clr_i_r, clr_i_nxt;
  logic [1:0]        req_r, req_nxt;
  logic [2:0]        lun_r, lun_nxt;
  logic [9:0]        idx_r, idx_nxt;
  logic              gc_r, gc_nxt;
  logic [PAW-1:0]    pa_r, pa_nxt;
  logic [LW-1:0]     l_r, l_nxt;
  logic [BW-1:0]     i_r, i_nxt;
  logic [PLW-1:0]    per_lun_r, per_lun_nxt;
  logic [CPW-1:0]    cap_r, cap_nxt;
  logic [BW-1:0]     head_r [LUN_COUNT];
  logic [BW-1:0]     head_nxt [LUN_COUNT];
  logic [BW-1:0]     tail_r [LUN_COUNT];
  logic [BW-1:0]     tail_nxt [LUN_COUNT];
  logic [BPLW-1:0]   total_r [LUN_COUNT];
  logic [BPLW-1:0]   total_nxt [LUN_COUNT];
  logic              out_strobe_r, out_strobe_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [BIDW-1:0]   out_bid_r, out_bid_nxt;
  logic [BPLW-1:0]   out_free_r, out_free_nxt;

  // memory ports
  logic [AW-1:0]  rd_addr;
  logic           mark_we, next_we, prev_we;
  logic [AW-1:0]  mark_wa, next_wa, prev_wa;
  logic [MKW-1:0] mark_wd, mark_rd;
  logic [BW-1:0]  next_wd, next_rd, prev_wd, prev_rd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // scratch for the update step
  logic           lun_ok, is_free, mapped, do_rm, do_ap;
  logic [BPLW-1:0] t, t_new;
  logic [BW-1:0]  h, tl;
  logic [2:0]     st;
  logic [BMW-1:0] bid_full;

  always_comb begin
    if (bpl_r == '0) begin
      bpl_eff = BPLW'(1);
    end else if (int'(bpl_r) > MAX_BLOCKS_PER_LUN) begin
      bpl_eff = BPLW'(MAX_BLOCKS_PER_LUN);
    end else begin
      bpl_eff = bpl_r;
    end
    ppb_eff = (ppb_r == '0) ? PPBW'(1) : ppb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpl_r <= RST_BPL;
      ppb_r <= RST_PPB;
      rsv_r <= RST_RSV;
      lim_r <= PAGE_ALL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BPL:   bpl_r <= cfg_wdata[BPLW-1:0];
        CFG_PPB:   ppb_r <= cfg_wdata[PPBW-1:0];
        CFG_RSV:   rsv_r <= cfg_wdata[BPLW-1:0];
        CFG_LIMIT: lim_r <= cfg_wdata[PAW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    clr_i_nxt      = clr_i_r;
    req_nxt        = req_r;
    lun_nxt        = lun_r;
    idx_nxt        = idx_r;
    gc_nxt         = gc_r;
    pa_nxt         = pa_r;
    l_nxt          = l_r;
    i_nxt          = i_r;
    per_lun_nxt    = per_lun_r;
    cap_nxt        = cap_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    total_nxt      = total_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_bid_nxt    = out_bid_r;
    out_free_nxt   = out_free_r;
    rd_addr        = slot(l_r, i_r);
    mark_we        = 1'b0;
    next_we        = 1'b0;
    prev_we        = 1'b0;
    mark_wa        = slot(l_r, i_r);
    next_wa        = slot(l_r, i_r);
    prev_wa        = slot(l_r, i_r);
    mark_wd        = mark_rd;
    next_wd        = next_rd;
    prev_wd        = prev_rd;
    div_req        = '0;
    lun_ok         = int'(lun_r) < LUN_COUNT;
    t              = total_r[l_r];
    h              = head_r[l_r];
    tl             = tail_r[l_r];
    is_free        = (mark_rd[1:0] == MK_FREE);
    mapped         = mark_rd[2];
    do_rm          = 1'b0;
    do_ap          = 1'b0;
    t_new          = t;
    st             = ST_OK;
    bid_full       = BMW'(l_r) * BMW'(bpl_eff) + BMW'(i_r);

    case (state_r)
      S_CLEAR: begin
        mark_we = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        mark_wa = clr_addr_r;
        next_wa = clr_addr_r;
        prev_wa = clr_addr_r;
        mark_wd = (clr_addr_r == '0) ? {1'b0, MK_USED} : {1'b0, MK_FREE};
        next_wd = clr_i_r + BW'(1);
        prev_wd = clr_i_r - BW'(1);
        for (int l = 0; l < LUN_COUNT; l++) begin
          head_nxt[l]  = (l == 0) ? BW'(1) : '0;
          tail_nxt[l]  = BW'(bpl_eff - BPLW'(1));
          total_nxt[l] = (l == 0) ? bpl_eff - BPLW'(1) : bpl_eff;
        end
        clr_i_nxt    = (clr_i_r == BW'(MAX_BLOCKS_PER_LUN - 1)) ? '0 : clr_i_r + BW'(1);
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req_type;
          lun_nxt   = in_lun;
          idx_nxt   = in_block_index;
          gc_nxt    = in_for_gc;
          pa_nxt    = in_page_address;
          l_nxt     = LW'(in_lun);
          state_nxt = (in_req_type == REQ_MAP) ? S_MUL : S_PRE;
        end
      end
      S_PRE: begin
        out_bid_nxt  = '0;
        out_free_nxt = t;
        if (!lun_ok) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_RANGE;
          out_free_nxt   = '0;
          state_nxt      = S_IDLE;
        end else if (req_r == REQ_GET) begin
          if (t == '0) begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = ST_EMPTY;
            state_nxt      = S_IDLE;
          end else if (!gc_r && t < rsv_r) begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = ST_RESERVE;
            state_nxt      = S_IDLE;
          end else begin
            i_nxt     = h;
            state_nxt = S_ADDR;
          end
        end else if (BPLW'(idx_r) >= bpl_eff) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_RANGE;
          state_nxt      = S_IDLE;
        end else begin
          i_nxt     = BW'(idx_r);
          state_nxt = S_ADDR;
        end
      end
      S_MUL: begin
        per_lun_nxt = PLW'(bpl_eff) * PLW'(ppb_eff);
        state_nxt   = S_CAP;
      end
      S_CAP: begin
        cap_nxt   = CPW'(per_lun_r) * CPW'(LUN_COUNT);
        state_nxt = S_CHKM;
      end
      S_CHKM: begin
        out_bid_nxt  = '0;
        out_free_nxt = '0;
        if (pa_r == PAGE_ALL || pa_r == '0) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_SKIP;
          state_nxt      = S_IDLE;
        end
        if (pa_r != PAGE_ALL && (pa_r >= lim_r || (pa_r != '0 && pa_r >= PAW'(cap_r)))) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_RANGE;
          state_nxt      = S_IDLE;
        end
        if (pa_r != PAGE_ALL && pa_r < lim_r && pa_r != '0 && pa_r < PAW'(cap_r)) begin
          div_req.start    = 1'b1;
          div_req.dividend = DVW'(pa_r);
          div_req.divisor  = DVW'(per_lun_r) << (LW - 1);
          div_req.steps    = SCW'(LW);
          state_nxt        = S_DIVL;
        end
      end
      S_DIVL: begin
        if (div_rsp.done) begin
          l_nxt            = div_rsp.quot[LW-1:0];
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.rem;
          div_req.divisor  = DVW'(ppb_eff) << (BW - 1);
          div_req.steps    = SCW'(BW);
          state_nxt        = S_DIVB;
        end
      end
      S_DIVB: begin
        if (div_rsp.done) begin
          i_nxt     = div_rsp.quot[BW-1:0];
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        case (req_r)
          REQ_GET: begin
            do_rm   = 1'b1;
            mark_we = 1'b1;
            mark_wd = {mapped, MK_USED};
          end
          REQ_PUT: begin
            if (is_free) begin
              st = ST_RANGE;
            end else begin
              do_ap   = 1'b1;
              mark_we = 1'b1;
              mark_wd = {mapped, MK_FREE};
            end
          end
          REQ_BAD: begin
            do_rm   = is_free;
            mark_we = 1'b1;
            mark_wd = {mapped, MK_BAD};
          end
          default: begin
            if (!mapped) begin
              do_rm   = is_free;
              mark_we = 1'b1;
              mark_wd = {1'b1, MK_USED};
            end
          end
        endcase
        // unlink from the free queue
        if (do_rm) begin
          if (t > BPLW'(1)) begin
            if (i_r == h) begin
              head_nxt[l_r] = next_rd;
            end else if (i_r == tl) begin
              tail_nxt[l_r] = prev_rd;
            end else begin
              next_we = 1'b1;
              next_wa = slot(l_r, prev_rd);
              next_wd = next_rd;
              prev_we = 1'b1;
              prev_wa = slot(l_r, next_rd);
              prev_wd = prev_rd;
            end
          end
          t_new = t - BPLW'(1);
        end
        // append at the tail
        if (do_ap) begin
          if (t == '0) begin
            head_nxt[l_r] = i_r;
          end else begin
            next_we = 1'b1;
            next_wa = slot(l_r, tl);
            next_wd = i_r;
            prev_we = 1'b1;
            prev_wa = slot(l_r, i_r);
            prev_wd = tl;
          end
          tail_nxt[l_r] = i_r;
          t_new         = t + BPLW'(1);
        end
        total_nxt[l_r] = t_new;
        out_strobe_nxt = 1'b1;
        out_status_nxt = st;
        out_bid_nxt    = bid_full[BIDW-1:0];
        out_free_nxt   = t_new;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a new LUN size rebuilds all block state
    if (cfg_we && cfg_index == CFG_BPL) begin
      state_nxt    = S_CLEAR;
      clr_addr_nxt = '0;
      clr_i_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      clr_i_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_i_r      <= clr_i_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    lun_r        <= lun_nxt;
    idx_r        <= idx_nxt;
    gc_r         <= gc_nxt;
    pa_r         <= pa_nxt;
    l_r          <= l_nxt;
    i_r          <= i_nxt;
    per_lun_r    <= per_lun_nxt;
    cap_r        <= cap_nxt;
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    total_r      <= total_nxt;
    out_status_r <= out_status_nxt;
    out_bid_r    <= out_bid_nxt;
    out_free_r   <= out_free_nxt;
  end

  fbfl_ram #(.WIDTH(MKW), .DEPTH(DEPTH)) u_mark_ram (
    .clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
    .raddr(rd_addr), .rdata(mark_rd)
  );

  fbfl_ram #(.WIDTH(BW), .DEPTH(DEPTH)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(rd_addr), .rdata(next_rd)
  );

  fbfl_ram #(.WIDTH(BW), .DEPTH(DEPTH)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(rd_addr), .rdata(prev_rd)
  );

  fbfl_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
  );

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_block_id   = out_bid_r;
  assign out_free_count = out_free_r;

endmodule
